// File: rtl/rvcq_pkg.sv
package rvcq_pkg;

	localparam int POS_W   = 11;
	localparam int COUNT_W = 11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} rvcq_state_t;

endpackage

// File: rtl/range_value_count_query_top.sv
// load beat: no result; the next beat is taken in the cycle after
// query beat: result register loaded after a scan of the window (none for an empty query),
// which reads through the single read port of the element memory, one element per cycle
// one beat at a time; a finished count may wait in the output register while the next beat enters
// arst_n clears the loaded count and the control state; memory contents are left as they are
module range_value_count_query_top #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int VALUE_WIDTH  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic signed [VALUE_WIDTH-1:0]    element_value,
	input  logic [rvcq_pkg::POS_W-1:0]       first_position,
	input  logic [rvcq_pkg::POS_W-1:0]       last_position,
	input  logic signed [VALUE_WIDTH-1:0]    value_low,
	input  logic signed [VALUE_WIDTH-1:0]    value_high,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rvcq_pkg::COUNT_W-1:0]     match_count
);
	import rvcq_pkg::*;

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int IW = (CW > POS_W) ? CW : POS_W;

	logic signed [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];

	rvcq_state_t state_q, state_d;

	logic [CW-1:0]                 loaded_q;
	logic [IW-1:0]                 idx_q;
	logic [IW-1:0]                 stop_q;
	logic signed [VALUE_WIDTH-1:0] lo_q;
	logic signed [VALUE_WIDTH-1:0] hi_q;
	logic [COUNT_W-1:0]            cnt_q;
	logic                          out_valid_q;
	logic [COUNT_W-1:0]            match_q;

	logic signed [VALUE_WIDTH-1:0] rdata_s1;
	logic                          rvld_s1;

	logic                          accept;
	logic                          do_load;
	logic                          rd_en;
	logic                          emit;
	logic [POS_W-1:0]              first_eff;
	logic [IW-1:0]                 start_w;
	logic [IW-1:0]                 last_w;
	logic [IW-1:0]                 loaded_w;
	logic [IW-1:0]                 stop_w;
	logic                          query_empty;
	logic                          hit;

	assign accept   = in_valid && !in_stall;
	assign do_load  = accept && !kind && (loaded_q < CW'(MAX_ELEMENTS));

	// position zero counts as position one
	assign first_eff = (first_position == '0) ? POS_W'(1) : first_position;
	assign start_w   = IW'(first_eff - POS_W'(1));
	assign last_w    = IW'(last_position);
	assign loaded_w  = IW'(loaded_q);
	assign stop_w    = (last_w > loaded_w) ? loaded_w : last_w;
	assign query_empty = (start_w >= stop_w) || (value_low > value_high);

	assign rd_en = (state_q == ST_SCAN) && (idx_q < stop_q);
	assign hit   = rvld_s1 && (rdata_s1 >= lo_q) && (rdata_s1 <= hi_q);

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && kind) begin
					state_d = query_empty ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				// last read has landed and been counted
				if (!rd_en && !rvld_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			mem[loaded_q[AW-1:0]] <= element_value;
		end
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_load) begin
				loaded_q <= loaded_q + CW'(1);
			end
			rvld_s1 <= rd_en;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind) begin
			idx_q  <= start_w;
			stop_q <= stop_w;
			lo_q   <= value_low;
			hi_q   <= value_high;
			cnt_q  <= '0;
		end else begin
			if (rd_en) begin
				idx_q <= idx_q + IW'(1);
			end
			if (hit) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
		end
		if (emit) begin
			match_q <= cnt_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = match_q;

endmodule

// File: tb/range_value_count_query_top_tb.sv
module range_value_count_query_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rvcq_pkg::*;

	localparam int STORE_DEPTH = 1024;
	localparam int VAL_W       = 32;
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
	localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef struct {
		logic                    kind;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        first;
		logic [POS_W-1:0]        last;
		logic signed [VAL_W-1:0] low;
		logic signed [VAL_W-1:0] high;
	} rvcq_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [COUNT_W-1:0] match_count;
	rvcq_beat_t beat = '{KIND_LOAD, '0, '0, '0, '0, '0};

	rvcq_beat_t pending_beats[$];
	logic [COUNT_W-1:0] expected_counts[$];

	// shadow of the element store, filled as loads are accepted
	logic signed [VAL_W-1:0] shadow_mem [0:STORE_DEPTH-1];
	int shadow_loaded = 0;
	int gen_loaded = 0;
	int beats_taken = 0;
	int total_beats = 0;
	int phase_sel = 0;
	int mismatches = 0;

	range_value_count_query_top #(
		.MAX_ELEMENTS(STORE_DEPTH),
		.VALUE_WIDTH (VAL_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (beat.kind),
		.element_value (beat.value),
		.first_position(beat.first),
		.last_position (beat.last),
		.value_low     (beat.low),
		.value_high    (beat.high),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.match_count   (match_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [COUNT_W-1:0] count_in_window(input rvcq_beat_t b);
		int start_idx;
		int stop_idx;
		int n;
		start_idx = (b.first == 0) ? 0 : int'(b.first) - 1;
		stop_idx = (int'(b.last) > shadow_loaded) ? shadow_loaded : int'(b.last);
		n = 0;
		if (b.low <= b.high) begin
			for (int i = start_idx; i < stop_idx; i++)
				if (shadow_mem[i] >= b.low && shadow_mem[i] <= b.high)
					n++;
		end
		return n[COUNT_W-1:0];
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// driver: predicts each accepted beat, then offers the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (beat.kind == KIND_LOAD) begin
					if (shadow_loaded < STORE_DEPTH) begin
						shadow_mem[shadow_loaded] = beat.value;
						shadow_loaded++;
					end
				end else begin
					expected_counts.insert(expected_counts.size(), count_in_window(beat));
				end
				beats_taken++;
				phase_sel <= (beats_taken / 64) % 4;
			end
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >=
						((phase_sel == 1) ? 54 : (phase_sel == 3) ? 8 : 0)) begin
					beat <= pending_beats.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure and in-order compare of counts
	always @(posedge clk) begin
		logic [COUNT_W-1:0] want;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) <
				((phase_sel == 2) ? 54 : (phase_sel == 3) ? 8 : 0));
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					note_mismatch("count with no query pending", -1, match_count);
				end else begin
					want = expected_counts.pop_front();
					if (match_count !== want)
						note_mismatch("match_count", want, match_count);
				end
			end
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(3))
					0: return VMIN;
					1: return VMAX;
					2: return VMIN + 1;
					default: return VMAX - 1;
				endcase
			end
			default: return $signed($urandom_range(32)) - 16;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(9))
			0: return '0;
			1: return POS_W'($urandom_range(2047));
			2: return POS_W'(STORE_DEPTH);
			3: return '1;
			default: return POS_W'($urandom_range(gen_loaded + 2, 1));
		endcase
	endfunction

	task automatic add_load(input logic signed [VAL_W-1:0] v);
		rvcq_beat_t b;
		// query fields are don't-care on a load, so fill them with noise
		b = '{KIND_LOAD, v, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom};
		pending_beats.insert(pending_beats.size(), b);
		if (gen_loaded < STORE_DEPTH)
			gen_loaded++;
	endtask

	task automatic add_query(input logic [POS_W-1:0] f, input logic [POS_W-1:0] l,
			input logic signed [VAL_W-1:0] lo, input logic signed [VAL_W-1:0] hi);
		rvcq_beat_t b;
		b = '{KIND_QUERY, $urandom, f, l, lo, hi};
		pending_beats.insert(pending_beats.size(), b);
	endtask

	task automatic add_random_query();
		logic [POS_W-1:0] f;
		logic [POS_W-1:0] l;
		logic [POS_W-1:0] tp;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		logic signed [VAL_W-1:0] tv;
		f = pick_position();
		l = pick_position();
		lo = pick_value();
		hi = pick_value();
		// mostly proper ranges and windows, some left inverted
		if (f > l && $urandom_range(3) != 0) begin
			tp = f; f = l; l = tp;
		end
		if (lo > hi && $urandom_range(4) != 0) begin
			tv = lo; lo = hi; hi = tv;
		end
		add_query(f, l, lo, hi);
	endtask

	initial begin
		// directed: empty store, extreme values, edge positions and windows
		add_query(POS_W'(1), POS_W'(1024), VMIN, VMAX);
		add_load(VMIN);
		add_load(VMAX);
		add_load(0);
		add_load(-1);
		add_load(1);
		add_load(5);
		add_load(5);
		add_query(POS_W'(1), POS_W'(1024), VMIN, VMAX);
		add_query(POS_W'(0), POS_W'(3), VMIN, VMIN);
		add_query(POS_W'(1), POS_W'(2047), 5, 5);
		add_query(POS_W'(5), POS_W'(2), VMIN, VMAX);
		add_query(POS_W'(1), POS_W'(7), 1, -1);
		add_query(POS_W'(8), POS_W'(1024), VMIN, VMAX);
		add_query(POS_W'(2), POS_W'(6), -1, 1);
		add_query(POS_W'(2), POS_W'(2), VMAX, VMAX);
		add_query(POS_W'(2047), POS_W'(2047), VMIN, VMAX);
		add_query(POS_W'(1024), POS_W'(1), VMIN, VMAX);

		for (int i = 0; i < 420; i++) begin
			if ($urandom_range(99) < 55)
				add_load(pick_value());
			else
				add_random_query();
		end

		// whole-store queries over everything loaded so far, one on position 1024 alone, then random queries
		add_query(POS_W'(1), POS_W'(2047), VMIN, VMAX);
		add_query(POS_W'(0), POS_W'(1024), VMIN, VMAX);
		add_query(POS_W'(1024), POS_W'(1024), VMIN, VMAX);
		for (int i = 0; i < 12; i++)
			add_random_query();

		total_beats = pending_beats.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_taken < total_beats)
			@(posedge clk);
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: range_value_count_query_top.f
rtl/rvcq_pkg.sv
rtl/range_value_count_query_top.sv
tb/range_value_count_query_top_tb.sv
